// ===== hdl/eccap_pkg.sv =====
// eccap_pkg: shared types and constants for the event clip capture trigger.
// Used by eccap_cell, eccap_ctrl and event_clip_capture_trigger; no dependencies.

package eccap_pkg;

   localparam int TAG_WIDTH     = 16;
   localparam int SCORE_WIDTH   = 32;
   localparam int THRESH_WIDTH  = 32;
   localparam int CTX_WIDTH     = 7;
   localparam int CSR_IDX_WIDTH = 4;
   localparam int CONTEXT_DEPTH_DEFAULT = 64;

   localparam logic [THRESH_WIDTH-1:0] THRESHOLD_RESET = 32'd10000000;
   localparam logic [CTX_WIDTH-1:0]    CTX_FRAMES_RESET = 7'd64;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_THRESHOLD  = 4'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CTX_FRAMES = 4'd1;

   typedef struct packed {
      logic [TAG_WIDTH-1:0]   frame_tag;
      logic [SCORE_WIDTH-1:0] surprise_score;
   } req_type;

   typedef struct packed {
      logic [TAG_WIDTH-1:0] save_tag;
      logic                 event_mark;
      logic                 close_clip;
      logic                 last;
   } rsp_type;

   // contents of one cell of the context chain
   typedef struct packed {
      logic [TAG_WIDTH-1:0] tag;
      logic                 mark;
   } cell_data_type;

   // chain control from the sequencer
   typedef struct packed {
      logic shift;   // every cell takes its neighbour's entry
      logic rotate;  // cell 0 takes the tail entry instead of the new frame
   } chain_ctl_type;

endpackage

// ===== hdl/eccap_cell.sv =====
// eccap_cell: one stage of the context chain, holding one frame tag and its mark.
// Depends on eccap_pkg.

module eccap_cell (
   input  logic                   clock,
   input  logic                   shift,
   input  eccap_pkg::cell_data_type data_in,
   output eccap_pkg::cell_data_type data_out
);
   import eccap_pkg::*;

   cell_data_type data_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

// ===== hdl/eccap_ctrl.sv =====
// eccap_ctrl: request sequencer, fill and countdown tracking, result register.
// Depends on eccap_pkg; drives the shift/rotate control of the cell chain.

module eccap_ctrl #(
   parameter int CONTEXT_DEPTH = eccap_pkg::CONTEXT_DEPTH_DEFAULT,
   parameter int FILL_W        = $clog2(CONTEXT_DEPTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  eccap_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output eccap_pkg::rsp_type                   rsp_data,
   input  logic [eccap_pkg::THRESH_WIDTH-1:0]   threshold,
   input  logic [FILL_W-1:0]                    ctx_len,
   input  eccap_pkg::cell_data_type             tail,
   output eccap_pkg::cell_data_type             new_cell,
   output eccap_pkg::chain_ctl_type             chain_ctl
);
   import eccap_pkg::*;

   localparam int STEP_W = $clog2(CONTEXT_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EMIT  = 4'b0010,
      ST_CLOSE = 4'b0100,
      ST_DUMP  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   countdown_ff, countdown_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   rsp_type             cur_ff, cur_in;
   logic                close_pend_ff, close_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             load_data;
   logic                load;
   logic                accept;
   logic                mark;
   logic                slot_free;
   logic                step_last;
   logic                dump_emit;

   assign mark      = (req_data.surprise_score >= threshold);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign step_last = (step_ff == STEP_W'(CONTEXT_DEPTH - 1));
   // the oldest held entry reaches the tail after DEPTH - fill rotations
   assign dump_emit = ((FILL_W + 1)'(step_ff) + (FILL_W + 1)'(fill_ff))
                      >= (FILL_W + 1)'(CONTEXT_DEPTH);

   assign new_cell.tag  = req_data.frame_tag;
   assign new_cell.mark = mark;

   always_comb begin
      state_in         = state_ff;
      fill_in          = fill_ff;
      countdown_in     = countdown_ff;
      step_in          = step_ff;
      cur_in           = cur_ff;
      close_pend_in    = close_pend_ff;
      load             = 1'b0;
      load_data        = '0;
      chain_ctl.shift  = 1'b0;
      chain_ctl.rotate = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               chain_ctl.shift = 1'b1;
               if (fill_ff < ctx_len) begin
                  fill_in = fill_ff + 1'b1;
               end
               cur_in.save_tag   = req_data.frame_tag;
               cur_in.event_mark = mark;
               cur_in.close_clip = 1'b0;
               cur_in.last       = 1'b1;
               close_pend_in     = 1'b0;
               if (mark) begin
                  countdown_in = ctx_len;
                  if (countdown_ff == '0) begin
                     state_in = ST_DUMP;
                     step_in  = '0;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end else if (countdown_ff != '0) begin
                  countdown_in = countdown_ff - 1'b1;
                  state_in     = ST_EMIT;
                  if (countdown_ff == FILL_W'(1)) begin
                     cur_in.last   = 1'b0;
                     close_pend_in = 1'b1;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load      = 1'b1;
               load_data = cur_ff;
               state_in  = close_pend_ff ? ST_CLOSE : ST_IDLE;
            end
         end
         ST_CLOSE: begin
            if (slot_free) begin
               load                 = 1'b1;
               load_data.close_clip = 1'b1;
               load_data.last       = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (slot_free) begin
               chain_ctl.shift  = 1'b1;
               chain_ctl.rotate = 1'b1;
               if (dump_emit) begin
                  load                 = 1'b1;
                  load_data.save_tag   = tail.tag;
                  load_data.event_mark = tail.mark;
                  load_data.last       = step_last;
               end
               if (step_last) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         countdown_ff  <= '0;
         step_ff       <= '0;
         close_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         countdown_ff  <= countdown_in;
         step_ff       <= step_in;
         close_pend_ff <= close_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (load) begin
         rsp_data_ff <= load_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CONTEXT_DEPTH) && countdown_ff <= FILL_W'(CONTEXT_DEPTH))
      else $error("fill or countdown beyond context depth");

   a_dump_start : assert property (@(posedge clock) disable iff (reset)
      (accept && mark && countdown_ff == '0) |=> (state_ff == ST_DUMP && step_ff == '0))
      else $error("event with no open clip did not start a ring dump");

   a_close_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.close_clip) |->
         (rsp_data_ff.save_tag == '0 && !rsp_data_ff.event_mark && rsp_data_ff.last))
      else $error("close marker carries frame data");

   a_dump_last : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP && slot_free && step_last) |=> (rsp_valid_ff && rsp_data_ff.last))
      else $error("ring dump ended without a final result");
`endif

endmodule

// ===== hdl/event_clip_capture_trigger.sv =====
// event_clip_capture_trigger: top level, configuration registers and context chain.
// Depends on eccap_pkg, eccap_cell and eccap_ctrl.
//
//   channel | ports                                | direction
//   --------+--------------------------------------+-----------
//   req     | req_valid, req_stall, req_data       | in
//   rsp     | rsp_valid, rsp_stall, rsp_data       | out
//   csr     | csr_valid, csr_ready, csr_index/data | in
//
// One request at a time; req_stall is high from acceptance until its results are
// registered. A single result is registered from the EMIT state, a closing pair from
// EMIT and then CLOSE; rsp_stall can hold either.
// An event with no open clip rotates the whole chain once, one step per cell,
// emitting the held frames oldest first. rsp_stall holds the rotation.
// Reset clears the fill and countdown; the chain itself needs no clearing.

module event_clip_capture_trigger #(
   parameter int CONTEXT_DEPTH = eccap_pkg::CONTEXT_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  eccap_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output eccap_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [eccap_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [eccap_pkg::THRESH_WIDTH-1:0]    csr_data
);
   import eccap_pkg::*;

   localparam int FILL_W = $clog2(CONTEXT_DEPTH + 1);

   logic [THRESH_WIDTH-1:0] threshold_ff;
   logic [CTX_WIDTH-1:0]    ctx_frames_ff;
   logic [31:0]             ctx32;
   logic [31:0]             len32;
   logic [FILL_W-1:0]       ctx_len;
   cell_data_type           chain [CONTEXT_DEPTH];
   cell_data_type           new_cell;
   cell_data_type           head_in;
   chain_ctl_type           chain_ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         ctx_frames_ff <= CTX_FRAMES_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD:  threshold_ff  <= csr_data;
            CSR_CTX_FRAMES: ctx_frames_ff <= csr_data[CTX_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // context length clamped to 1..CONTEXT_DEPTH
   assign ctx32 = 32'(ctx_frames_ff);
   always_comb begin
      if (ctx32 == 32'd0) begin
         len32 = 32'd1;
      end else if (ctx32 > 32'(CONTEXT_DEPTH)) begin
         len32 = 32'(CONTEXT_DEPTH);
      end else begin
         len32 = ctx32;
      end
   end
   assign ctx_len = len32[FILL_W-1:0];

   // cell 0 holds the newest frame; the tail wraps round to cell 0 during a dump
   assign head_in = chain_ctl.rotate ? chain[CONTEXT_DEPTH-1] : new_cell;

   for (genvar k = 0; k < CONTEXT_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         eccap_cell u_cell (
            .clock    (clock),
            .shift    (chain_ctl.shift),
            .data_in  (head_in),
            .data_out (chain[k])
         );
      end else begin : g_body
         eccap_cell u_cell (
            .clock    (clock),
            .shift    (chain_ctl.shift),
            .data_in  (chain[k-1]),
            .data_out (chain[k])
         );
      end
   end

   eccap_ctrl #(
      .CONTEXT_DEPTH (CONTEXT_DEPTH),
      .FILL_W        (FILL_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .threshold (threshold_ff),
      .ctx_len   (ctx_len),
      .tail      (chain[CONTEXT_DEPTH-1]),
      .new_cell  (new_cell),
      .chain_ctl (chain_ctl)
   );

endmodule

// ===== sim/event_clip_capture_trigger_tb.sv =====
// event_clip_capture_trigger_tb: self-checking bench for the pre/post event clip trigger.
// It predicts every saved frame and close-clip marker and drives frames, CSR writes and stalls.
// Depends on eccap_pkg and event_clip_capture_trigger.
`timescale 1ns / 100ps

module event_clip_capture_trigger_tb;
   import eccap_pkg::*;

   localparam int DEPTH          = CONTEXT_DEPTH_DEFAULT;
   localparam int HEAD_W         = $clog2(DEPTH);
   localparam int SETTLE_CYCLES  = DEPTH + 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   // indexes past the register list, writes to them are dropped
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE = 4'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TOP   = 4'd15;

   class clip_tracker;
      logic [THRESH_WIDTH-1:0] threshold;
      logic [CTX_WIDTH-1:0]    ctx_frames;
      logic [TAG_WIDTH-1:0]    ring_tag [DEPTH];
      logic                    ring_mark [DEPTH];
      logic [HEAD_W-1:0]       head;
      logic [CTX_WIDTH-1:0]    fill;
      logic [CTX_WIDTH-1:0]    countdown;
      rsp_type                 due_saves [$];
      int                      errors;
      int                      saves_checked;
      int                      clips_closed;

      function new();
         threshold     = THRESHOLD_RESET;
         ctx_frames    = CTX_FRAMES_RESET;
         head          = '0;
         fill          = '0;
         countdown     = '0;
         errors        = 0;
         saves_checked = 0;
         clips_closed  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_WIDTH-1:0] index, logic [THRESH_WIDTH-1:0] value);
         case (index)
            CSR_THRESHOLD:  threshold = value;
            CSR_CTX_FRAMES: ctx_frames = value[CTX_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function void queue_save(logic [TAG_WIDTH-1:0] tag, logic mark, logic close, logic fin);
         rsp_type s;
         s.save_tag   = tag;
         s.event_mark = mark;
         s.close_clip = close;
         s.last       = fin;
         due_saves.insert(due_saves.size(), s);
      endfunction

      function rsp_type take_due();
         rsp_type s;
         s = due_saves[0];
         due_saves.delete(0);
         return s;
      endfunction

      function void note_frame(req_type frame);
         logic [CTX_WIDTH-1:0] span;
         logic [HEAD_W-1:0]    slot;
         logic                 marked;
         int                   i;
         span   = CTX_WIDTH'((ctx_frames == 0) ? 1 : (ctx_frames > DEPTH) ? DEPTH : ctx_frames);
         marked = (frame.surprise_score >= threshold);
         if (fill < DEPTH) begin
            slot            = head + fill[HEAD_W-1:0];
            ring_tag[slot]  = frame.frame_tag;
            ring_mark[slot] = marked;
            fill++;
            // a shortened context only sheds one oldest entry per frame
            if (fill > span) begin
               head++;
               fill--;
            end
         end else begin
            ring_tag[head]  = frame.frame_tag;
            ring_mark[head] = marked;
            head++;
         end
         if (marked) begin
            if (countdown != 0) begin
               queue_save(frame.frame_tag, 1'b1, 1'b0, 1'b1);
            end else begin
               for (i = 0; i < fill; i++) begin
                  slot = head + i[HEAD_W-1:0];
                  queue_save(ring_tag[slot], ring_mark[slot], 1'b0, (i + 1 == fill));
               end
            end
            countdown = span;
         end else if (countdown != 0) begin
            countdown--;
            if (countdown == 0) begin
               queue_save(frame.frame_tag, 1'b0, 1'b0, 1'b0);
               queue_save('0, 1'b0, 1'b1, 1'b1);
            end else begin
               queue_save(frame.frame_tag, 1'b0, 1'b0, 1'b1);
            end
         end
      endfunction

      function void check_save(rsp_type got);
         rsp_type want;
         if (due_saves.size() == 0) begin
            $error("unexpected save: save_tag %h close_clip %b", got.save_tag, got.close_clip);
            errors++;
            return;
         end
         want = take_due();
         saves_checked++;
         if (want.close_clip) clips_closed++;
         if (got.save_tag !== want.save_tag) begin
            $error("save_tag: expected %h, got %h", want.save_tag, got.save_tag);
            errors++;
         end
         if (got.event_mark !== want.event_mark) begin
            $error("event_mark: expected %b, got %b", want.event_mark, got.event_mark);
            errors++;
         end
         if (got.close_clip !== want.close_clip) begin
            $error("close_clip: expected %b, got %b", want.close_clip, got.close_clip);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index;
   logic [THRESH_WIDTH-1:0]   csr_data;

   clip_tracker tracker = new();

   int idle_pct        = 0;
   int recv_pct        = 0;
   int pressure_asked  = 0;
   int pressure_served = 0;
   int frames_sent     = 0;
   int csr_writes      = 0;
   int quiet_cycles    = 0;

   event_clip_capture_trigger #(
      .CONTEXT_DEPTH(DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_save(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a handshake", quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off when asked
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_served != pressure_asked) begin
            pressure_served++;
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_pct);
      end
   end

   task automatic send_frame(input logic [TAG_WIDTH-1:0] tag, input logic [SCORE_WIDTH-1:0] score);
      req_type frame;
      frame.frame_tag      = tag;
      frame.surprise_score = score;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= frame;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_frame(frame);
      frames_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] index,
                            input logic [THRESH_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_reg(index, value);
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every predicted save, then for any unseen work to finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.due_saves.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SCORE_WIDTH-1:0] pick_score(int event_pct, int noise_pct);
      logic [THRESH_WIDTH-1:0] thr;
      int                      roll;
      thr  = tracker.threshold;
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) return $urandom;
      if (roll < noise_pct + event_pct) begin
         return ($urandom_range(0, 9) == 0) ? thr : $urandom_range(32'hFFFF_FFFF, thr);
      end
      if (thr == 0) return '0;
      return ($urandom_range(0, 9) == 0) ? thr - 1 : $urandom_range(thr - 1, 0);
   endfunction

   task automatic run_frames(input int count, input int event_pct, input int noise_pct);
      repeat (count) begin
         send_frame(16'($urandom_range(0, 16'hFFFF)), pick_score(event_pct, noise_pct));
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, event opens a clip with the short ring
      send_frame(16'h0000, 32'd0);
      send_frame(16'hFFFF, 32'd9_999_999);
      send_frame(16'hA5A5, 32'd10_000_000);
      send_frame(16'h5A5A, 32'hFFFF_FFFF);
      send_frame(16'h0001, 32'd1);

      // shorter context while the ring holds more, then close a clip
      settle();
      write_reg(CSR_CTX_FRAMES, 32'd2);
      send_frame(16'h8000, 32'h8000_0000);
      send_frame(16'h7FFF, 32'd5);
      send_frame(16'h0002, 32'd0);
      send_frame(16'h0003, 32'd10_000_001);

      // zero context behaves as one; zero threshold marks everything
      settle();
      write_reg(CSR_THRESHOLD, 32'd0);
      write_reg(CSR_CTX_FRAMES, 32'd0);
      send_frame(16'h1111, 32'd0);
      send_frame(16'h2222, 32'd0);

      settle();
      write_reg(CSR_THRESHOLD, 32'hFFFF_FFFF);
      send_frame(16'h3333, 32'hFFFF_FFFE);
      send_frame(16'h4444, 32'hFFFF_FFFF);

      // out-of-list indexes are dropped; oversize context clamps to the depth
      settle();
      write_reg(CSR_SPARE, 32'd0);
      write_reg(CSR_TOP, 32'd3);
      write_reg(CSR_CTX_FRAMES, 32'hFFFF_FFFF);
      send_frame(16'h0F0F, 32'hFFFF_FFFF);
      send_frame(16'hF0F0, 32'd0);

      // random phases, short clips, no idling
      settle();
      write_reg(CSR_THRESHOLD, THRESHOLD_RESET);
      write_reg(CSR_CTX_FRAMES, 32'd4);
      run_frames(12, 12, 8);

      settle();
      write_reg(CSR_THRESHOLD, $urandom);
      write_reg(CSR_CTX_FRAMES, {25'($urandom_range(0, 32'h1FF_FFFF)), 7'd1});
      idle_pct = 65;
      run_frames(10, 15, 10);

      settle();
      write_reg(CSR_THRESHOLD, $urandom_range(32'h00FF_FFFF, 1000));
      write_reg(CSR_CTX_FRAMES, 32'd8);
      idle_pct = 0;
      recv_pct = 65;
      run_frames(12, 12, 8);

      // long receiver hold-off while frames keep coming
      settle();
      write_reg(CSR_CTX_FRAMES, 32'd16);
      recv_pct = 0;
      pressure_asked++;
      run_frames(10, 20, 8);

      // fill the whole ring with quiet frames, then release it in one clip
      settle();
      write_reg(CSR_THRESHOLD, THRESHOLD_RESET);
      write_reg(CSR_CTX_FRAMES, 32'(DEPTH));
      idle_pct = 26;
      recv_pct = 26;
      run_frames(50, 0, 0);
      send_frame(16'($urandom_range(0, 16'hFFFF)),
                 $urandom_range(32'hFFFF_FFFF, THRESHOLD_RESET));

      settle();
      while (tracker.due_saves.size() != 0) begin
         $error("save_tag %h never arrived", tracker.due_saves[0].save_tag);
         tracker.due_saves.delete(0);
         tracker.errors++;
      end

      $display("Covered %0d frames and %0d register writes, thresholds 0..max, context 0..127;",
               frames_sent, csr_writes);
      $display("%0d saves checked, %0d clips closed, under sender idling and receiver stalls.",
               tracker.saves_checked, tracker.clips_closed);
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/eccap_pkg.sv
hdl/eccap_cell.sv
hdl/eccap_ctrl.sv
hdl/event_clip_capture_trigger.sv
sim/event_clip_capture_trigger_tb.sv
